### sv/cic_pkg.sv
// shared types, codes and constants for the cloud-in-cell charge deposit block
package cic_pkg;

  // default sizing
  localparam int NODES_DEF     = 1024;
  localparam int FRAC_BITS_DEF = 16;

  // fixed field widths
  localparam int DATA_W      = 32;
  localparam int NODES_CFG_W = 11;
  localparam int OP_W        = 2;
  localparam int READ_W      = 10;
  localparam int CFG_IDX_W   = 2;
  localparam int IDX_MAX_W   = 16;
  localparam int CONTRIB_W   = DATA_W + 4;
  localparam int FIFO_DEPTH  = 4;

  // opcodes, also used as the queued command kind
  localparam logic [OP_W-1:0] OP_DEPOSIT = OP_W'(0);
  localparam logic [OP_W-1:0] OP_CLEAR   = OP_W'(1);
  localparam logic [OP_W-1:0] OP_READ    = OP_W'(2);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CHARGE_PER_CELL = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PERIODIC_MODE   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_NODES_IN_USE    = CFG_IDX_W'(2);

  // configuration seen by the front end
  typedef struct packed {
    logic signed [DATA_W-1:0]  charge_per_cell;
    logic                      periodic_mode;
    logic [NODES_CFG_W-1:0]    nodes_in_use;
  } cic_cfg_t;

  // one command handed from front end to back end
  typedef struct packed {
    logic [OP_W-1:0]             kind;
    logic [IDX_MAX_W-1:0]        idx0;
    logic [IDX_MAX_W-1:0]        idx1;
    logic signed [CONTRIB_W-1:0] c0;
    logic signed [CONTRIB_W-1:0] c1;
    logic [READ_W-1:0]           rd_node;
    logic                        rd_zero;
  } cic_entry_t;

endpackage

### sv/cic_front.sv
// front end: accepts words, splits the position, weights the charge and queues commands
module cic_front #(
  parameter int NODES     = cic_pkg::NODES_DEF,
  parameter int FRAC_BITS = cic_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  cic_pkg::cic_cfg_t                  cfg,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [cic_pkg::OP_W-1:0]           in_opcode,
  input  logic signed [cic_pkg::DATA_W-1:0]  in_position,
  input  logic                               in_alive,
  input  logic [cic_pkg::READ_W-1:0]         in_read_node,
  output logic                               push_valid,
  input  logic                               push_ready,
  output cic_pkg::cic_entry_t                push_entry
);
  import cic_pkg::*;

  localparam int NW    = $clog2(NODES + 1);
  localparam int IW    = $clog2(NODES);
  localparam int IPW   = DATA_W - FRAC_BITS;
  localparam int WW    = FRAC_BITS + 3;
  localparam int PW    = DATA_W + WW;
  localparam int RW    = PW - FRAC_BITS;
  localparam int CNT_W = $clog2(IPW + 1);

  localparam logic [2:0] F_IDLE  = 3'd0;
  localparam logic [2:0] F_DIV   = 3'd1;
  localparam logic [2:0] F_SPLIT = 3'd2;
  localparam logic [2:0] F_MUL   = 3'd3;
  localparam logic [2:0] F_PUSH  = 3'd4;

  logic [2:0]              state_r, state_nxt;
  logic [OP_W-1:0]         op_r;
  logic [READ_W-1:0]       rd_node_r;
  logic [NW-1:0]           cell_r;
  logic [FRAC_BITS-1:0]    frac_r;
  logic                    neg_r;
  logic [IPW-1:0]          quo_r;
  logic [NW-1:0]           rem_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [IW-1:0]           i_r, i1_r;
  logic signed [WW-1:0]    w0_r, w1_r;
  logic                    end0_r, end1_r;
  logic signed [PW-1:0]    p0_r, p1_r;

  logic                    accept;
  logic [31:0]             n_ext;
  logic [NW-1:0]           n, n_m1, n_m2;
  logic [IPW-1:0]          ip_u, ip_mag;
  logic [FRAC_BITS-1:0]    fr;
  logic [NW-1:0]           cell_clamp;
  logic [FRAC_BITS-1:0]    frac_clamp;
  logic [NW:0]             trial;
  logic [NW-1:0]           rem_step;
  logic [NW-1:0]           cell_mod, cell_sel, i_sel, i1_sel, d_sel, i_inc;
  logic [FRAC_BITS+1:0]    f_sel;
  logic signed [WW-1:0]    w1_sel, w0_sel;
  logic signed [PW-1:0]    half, q0, q1;
  logic signed [RW-1:0]    r0, r1;

  // node count clamped between 2 and the storage size
  assign n_ext = 32'(cfg.nodes_in_use);
  assign n     = (n_ext < 32'd2) ? NW'(2) :
                 ((n_ext > 32'(NODES)) ? NW'(NODES) : NW'(n_ext));
  assign n_m1  = n - NW'(1);
  assign n_m2  = n - NW'(2);

  assign in_ready = (state_r == F_IDLE);
  assign accept   = in_valid && in_ready;

  // integer part and fraction of the incoming position
  assign ip_u   = in_position[DATA_W-1:FRAC_BITS];
  assign fr     = in_position[FRAC_BITS-1:0];
  assign ip_mag = ip_u[IPW-1] ? IPW'(~ip_u + 1'b1) : ip_u;

  // bounded mode clamp to [0, n] cells
  always_comb begin
    if (in_position[DATA_W-1]) begin
      cell_clamp = '0;
      frac_clamp = '0;
    end else if (32'(ip_u) >= 32'(n)) begin
      cell_clamp = n;
      frac_clamp = '0;
    end else begin
      cell_clamp = NW'(ip_u);
      frac_clamp = fr;
    end
  end

  // one restoring step of the cell-index remainder
  assign trial    = {rem_r, quo_r[IPW-1]};
  assign rem_step = (trial >= {1'b0, n}) ? NW'(trial - {1'b0, n}) : NW'(trial);

  // cell index, neighbor and weights
  assign cell_mod = (neg_r && (rem_r != '0)) ? (n - rem_r) : rem_r;
  assign cell_sel = cfg.periodic_mode ? cell_mod : cell_r;
  assign i_sel    = (!cfg.periodic_mode && (cell_sel > n_m2)) ? n_m2 : cell_sel;
  assign i_inc    = i_sel + NW'(1);
  assign i1_sel   = (i_inc == n) ? '0 : i_inc;
  assign d_sel    = cell_sel - i_sel;
  assign f_sel    = {d_sel[1:0], frac_r};
  assign w1_sel   = WW'({1'b0, f_sel});
  assign w0_sel   = (WW'(1) << FRAC_BITS) - w1_sel;

  // rounding of the weighted charge, ties toward plus infinity
  assign half = PW'(1) << (FRAC_BITS - 1);
  assign q0   = p0_r + half;
  assign q1   = p1_r + half;
  assign r0   = q0[PW-1:FRAC_BITS];
  assign r1   = q1[PW-1:FRAC_BITS];

  // command toward the back end
  always_comb begin
    push_entry.kind    = op_r;
    push_entry.idx0    = IDX_MAX_W'(i_r);
    push_entry.idx1    = IDX_MAX_W'(i1_r);
    push_entry.c0      = end0_r ? {r0, 1'b0} : {r0[RW-1], r0};
    push_entry.c1      = end1_r ? {r1, 1'b0} : {r1[RW-1], r1};
    push_entry.rd_node = rd_node_r;
    push_entry.rd_zero = (32'(rd_node_r) >= 32'(NODES));
  end
  assign push_valid = (state_r == F_PUSH);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          unique case (in_opcode)
            OP_DEPOSIT: begin
              if (in_alive) state_nxt = cfg.periodic_mode ? F_DIV : F_SPLIT;
            end
            OP_CLEAR, OP_READ: state_nxt = F_PUSH;
            default: state_nxt = F_IDLE;
          endcase
        end
      end
      F_DIV:   if (cnt_r == CNT_W'(1)) state_nxt = F_SPLIT;
      F_SPLIT: state_nxt = F_MUL;
      F_MUL:   state_nxt = F_PUSH;
      F_PUSH:  if (push_ready) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r      <= in_opcode;
      rd_node_r <= in_read_node;
      cell_r    <= cell_clamp;
      frac_r    <= cfg.periodic_mode ? fr : frac_clamp;
      neg_r     <= ip_u[IPW-1];
      quo_r     <= ip_mag;
      rem_r     <= '0;
      cnt_r     <= CNT_W'(IPW);
    end else if (state_r == F_DIV) begin
      quo_r <= quo_r << 1;
      rem_r <= rem_step;
      cnt_r <= cnt_r - CNT_W'(1);
    end
    if (state_r == F_SPLIT) begin
      i_r    <= IW'(i_sel);
      i1_r   <= IW'(i1_sel);
      w0_r   <= w0_sel;
      w1_r   <= w1_sel;
      end0_r <= !cfg.periodic_mode && (i_sel == '0);
      end1_r <= !cfg.periodic_mode && (i1_sel == n_m1);
    end
    if (state_r == F_MUL) begin
      p0_r <= $signed(cfg.charge_per_cell) * w0_r;
      p1_r <= $signed(cfg.charge_per_cell) * w1_r;
    end
  end

endmodule

### sv/cic_fifo.sv
// short command queue between the front and back ends
module cic_fifo #(
  parameter int WIDTH = $bits(cic_pkg::cic_entry_t),
  parameter int DEPTH = cic_pkg::FIFO_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_data;
  end

endmodule

### sv/cic_back.sv
// back end: node charge memory, read-modify-write of deposits, clear sweep and reads
module cic_back #(
  parameter int NODES = cic_pkg::NODES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              head_valid,
  output logic                              head_pop,
  input  cic_pkg::cic_entry_t               head,
  output logic                              init_busy,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [cic_pkg::READ_W-1:0]        out_node_index,
  output logic signed [cic_pkg::DATA_W-1:0] out_node_charge
);
  import cic_pkg::*;

  localparam int IW = $clog2(NODES);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_DEP0 = 3'd1;
  localparam logic [2:0] B_DEP1 = 3'd2;
  localparam logic [2:0] B_READ = 3'd3;
  localparam logic [2:0] B_CLR  = 3'd4;

  logic [DATA_W-1:0]        charge_mem [NODES];
  logic [DATA_W-1:0]        rdata_r;
  logic [2:0]               state_r, state_nxt;
  logic [IW-1:0]            clr_cnt_r, clr_cnt_nxt;
  logic                     init_r, init_nxt;
  logic                     out_valid_r;
  logic [READ_W-1:0]        out_index_r;
  logic signed [DATA_W-1:0] out_charge_r;

  logic [IW-1:0]            raddr, waddr;
  logic                     we;
  logic [DATA_W-1:0]        wdata;
  logic                     out_load;
  logic                     clr_last;

  // saturating add of a contribution to a stored charge
  function automatic logic [DATA_W-1:0] sat_add(input logic signed [DATA_W-1:0] a,
                                                input logic signed [CONTRIB_W-1:0] c);
    logic signed [CONTRIB_W:0] s;
    logic [CONTRIB_W-DATA_W+1:0] top;
    s   = a + c;
    top = s[CONTRIB_W:DATA_W-1];
    if ((&top) || !(|top)) begin
      sat_add = s[DATA_W-1:0];
    end else if (s[CONTRIB_W]) begin
      sat_add = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sat_add = {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

  assign clr_last  = (clr_cnt_r == IW'(NODES - 1));
  assign init_busy = init_r;

  // command sequencer
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    init_nxt    = init_r;
    raddr       = head.idx0[IW-1:0];
    waddr       = head.idx0[IW-1:0];
    we          = 1'b0;
    wdata       = '0;
    head_pop    = 1'b0;
    out_load    = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (head_valid) begin
          unique case (head.kind)
            OP_DEPOSIT: state_nxt = B_DEP0;
            OP_CLEAR:   state_nxt = B_CLR;
            OP_READ: begin
              raddr     = IW'(head.rd_node);
              state_nxt = B_READ;
            end
            default: head_pop = 1'b1;
          endcase
        end
      end
      B_DEP0: begin
        raddr     = head.idx1[IW-1:0];
        we        = 1'b1;
        waddr     = head.idx0[IW-1:0];
        wdata     = sat_add(rdata_r, head.c0);
        state_nxt = B_DEP1;
      end
      B_DEP1: begin
        we        = 1'b1;
        waddr     = head.idx1[IW-1:0];
        wdata     = sat_add(rdata_r, head.c1);
        head_pop  = 1'b1;
        state_nxt = B_IDLE;
      end
      B_READ: begin
        raddr = IW'(head.rd_node);
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          head_pop  = 1'b1;
          state_nxt = B_IDLE;
        end
      end
      B_CLR: begin
        we    = 1'b1;
        waddr = clr_cnt_r;
        wdata = '0;
        if (clr_last) begin
          clr_cnt_nxt = '0;
          head_pop    = !init_r;
          init_nxt    = 1'b0;
          state_nxt   = B_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + IW'(1);
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // control state; reset starts a clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLR;
      clr_cnt_r   <= '0;
      init_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      init_r      <= init_nxt;
      out_valid_r <= out_load || (out_valid_r && !out_ready);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_index_r  <= head.rd_node;
      out_charge_r <= head.rd_zero ? '0 : rdata_r;
    end
  end

  // charge memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) charge_mem[waddr] <= wdata;
    rdata_r <= charge_mem[raddr];
  end

  assign out_valid       = out_valid_r;
  assign out_node_index  = out_index_r;
  assign out_node_charge = out_charge_r;

endmodule

### sv/cloud_in_cell_charge_deposit_top.sv
// Cloud-in-cell charge deposition into a node charge memory of NODES entries. The front end
// takes an opcode word when in_ready is high: a bounded-mode deposit passes its split,
// multiply and push states there, a periodic-mode deposit first a divide state because its
// cell index is reduced modulo the node count one bit per cycle, and a clear or read only
// the push state. Commands then wait in a 4-deep queue for the back end, which owns the
// single memory port pair: a deposit is a read-modify-write of two nodes, a read may wait
// on out_ready, and a clear writes one node per cycle after dispatch. Dead particles and
// the unused opcode give no result. After reset the back end clears the memory, and
// in_ready stays low until that pass ends; configuration writes are taken at any time but
// belong in idle periods.
module cloud_in_cell_charge_deposit_top #(
  parameter int NODES     = cic_pkg::NODES_DEF,
  parameter int FRAC_BITS = cic_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [cic_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [cic_pkg::DATA_W-1:0]           cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [cic_pkg::OP_W-1:0]             in_opcode,
  input  logic signed [cic_pkg::DATA_W-1:0]    in_position,
  input  logic                                 in_alive,
  input  logic [cic_pkg::READ_W-1:0]           in_read_node,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [cic_pkg::READ_W-1:0]           out_node_index,
  output logic signed [cic_pkg::DATA_W-1:0]    out_node_charge
);
  import cic_pkg::*;

  localparam logic [NODES_CFG_W-1:0] NODES_RESET = NODES_CFG_W'(1024);

  cic_cfg_t   cfg_r;
  logic       front_ready, front_valid, init_busy;
  logic       push_valid, push_ready, pop_valid, head_pop;
  cic_entry_t push_entry, head;
  logic [$bits(cic_entry_t)-1:0] pop_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.charge_per_cell <= DATA_W'(1) << FRAC_BITS;
      cfg_r.periodic_mode   <= 1'b1;
      cfg_r.nodes_in_use    <= NODES_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CHARGE_PER_CELL: cfg_r.charge_per_cell <= cfg_wdata;
        REG_PERIODIC_MODE:   cfg_r.periodic_mode   <= cfg_wdata[0];
        REG_NODES_IN_USE:    cfg_r.nodes_in_use    <= cfg_wdata[NODES_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // hold off input words during the clearing pass after reset
  assign front_valid = in_valid && !init_busy;
  assign in_ready    = front_ready && !init_busy;

  cic_front #(
    .NODES     (NODES),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (front_valid),
    .in_ready     (front_ready),
    .in_opcode    (in_opcode),
    .in_position  (in_position),
    .in_alive     (in_alive),
    .in_read_node (in_read_node),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_entry   (push_entry)
  );

  cic_fifo #(
    .WIDTH ($bits(cic_entry_t)),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (head_pop),
    .pop_data   (pop_data)
  );

  assign head = cic_entry_t'(pop_data);

  cic_back #(
    .NODES (NODES)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (pop_valid),
    .head_pop        (head_pop),
    .head            (head),
    .init_busy       (init_busy),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_node_index  (out_node_index),
    .out_node_charge (out_node_charge)
  );

endmodule

### sv/cic_checker.sv
// port-level checks for the charge deposit block, bound to the top level
module cic_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic [cic_pkg::OP_W-1:0]             in_opcode,
  input logic                                 in_alive,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic [cic_pkg::READ_W-1:0]           out_node_index,
  input logic signed [cic_pkg::DATA_W-1:0]    out_node_charge
);
  import cic_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_node_index) &&
                                $stable(out_node_charge))
    else $error("result word changed while stalled");

  // reset drops the result channel
  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // reset starts the clearing pass, so no word is taken right after it
  a_reset_in: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input ready during clearing pass");

  // a word that does work keeps the front end busy for the next cycle
  a_busy_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready &&
    (in_opcode == OP_READ || in_opcode == OP_CLEAR || (in_opcode == OP_DEPOSIT && in_alive))
    |=> !in_ready)
    else $error("input ready right after a working word");

endmodule

bind cloud_in_cell_charge_deposit_top cic_checker u_cic_checker (.*);
